@@ rtl/kmdeq_pkg.sv @@
// shared types, register indexes and defaults of the key matrix debounce event queue
package kmdeq_pkg;

  // default sizes
  localparam int unsigned MAX_ROW_COUNT_DEF    = 16;
  localparam int unsigned MAX_COLUMN_COUNT_DEF = 16;
  localparam int unsigned RING_SLOTS_DEF       = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_TIME  = 2'd0;
  localparam logic [1:0] CFG_ROWS_IN_USE    = 2'd1;
  localparam logic [1:0] CFG_COLUMNS_IN_USE = 2'd2;

  // register reset values
  localparam logic [15:0] DEBOUNCE_RESET = 16'd5;

  // item operations
  localparam logic OP_ROW_SAMPLE = 1'b0;
  localparam logic OP_POP        = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [3:0]  row_index;
    logic [15:0] column_levels;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       event_valid;
    logic [3:0] event_row;
    logic [3:0] event_column;
    logic       event_pressed;
  } out_item_t;

  // one queued key event
  typedef struct packed {
    logic [3:0] row;
    logic [3:0] column;
    logic       pressed;
  } ring_entry_t;

  // ring control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  // ring status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

@@ rtl/kmdeq_ring.sv @@
// event ring: slot memory with write and read pointers
module kmdeq_ring #(
  parameter int unsigned RING_SLOTS = kmdeq_pkg::RING_SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kmdeq_pkg::ring_ctrl_t  ctrl_i,
  input  kmdeq_pkg::ring_entry_t push_event_i,
  output kmdeq_pkg::ring_stat_t  stat_o,
  output kmdeq_pkg::ring_entry_t pop_event_o
);
  import kmdeq_pkg::*;

  localparam int unsigned PW = $clog2(RING_SLOTS);

  ring_entry_t ring_mem [RING_SLOTS];
  ring_entry_t rd_q;
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PW-1:0] wp_next, rp_next;
  logic          do_push, do_pop;

  // pointer wrap and status
  assign wp_next = (wp_q == PW'(RING_SLOTS - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == PW'(RING_SLOTS - 1)) ? '0 : rp_q + 1'b1;
  assign stat_o.empty = (wp_q == rp_q);
  assign stat_o.full  = (wp_next == rp_q);

  assign do_push = ctrl_i.push && !stat_o.full;
  assign do_pop  = ctrl_i.pop && !stat_o.empty;

  assign wp_d = do_push ? wp_next : wp_q;
  assign rp_d = do_pop ? rp_next : rp_q;

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ring_mem[wp_q] <= push_event_i;
    end
    if (do_pop) begin
      rd_q <= ring_mem[rp_q];
    end
  end

  assign pop_event_o = rd_q;

`ifndef SYNTH
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < RING_SLOTS) else $error("ring write pointer out of range");
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push && stat_o.full |=> $stable(wp_q)) else $error("push into full ring moved pointer");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop && stat_o.empty && !ctrl_i.push |=> stat_o.empty)
    else $error("pop from empty ring left ring non-empty");
`endif

endmodule

@@ rtl/key_matrix_debounce_event_queue_core.sv @@
// top level: key state memory, column scan sequencer, config and output register
//
// channel  direction  handshake                    payload
// in       input      in_valid_i / in_stall_o      in_data_i  (in_item_t)
// out      output     out_valid_o / out_stall_i    out_data_o (out_item_t)
// cfg      input      cfg_we_i, no wait            cfg_index_i, cfg_data_i
//
// a row sample is scanned one column per cycle through the key state memory read port,
// each key read in one cycle and written back the next, then a drain state ends the scan
// a sample outside the row range or with no columns is dropped without a scan; a pop
// reads the ring at once and loads its result into the output register when free
// reset clears key state through per-key valid bits at once, no clearing pass
// a pop result waits in the output register while out_stall_i is high; row samples
// are still taken meanwhile, a further pop waits for the register to free
module key_matrix_debounce_event_queue_core #(
  parameter int unsigned MAX_ROW_COUNT    = kmdeq_pkg::MAX_ROW_COUNT_DEF,
  parameter int unsigned MAX_COLUMN_COUNT = kmdeq_pkg::MAX_COLUMN_COUNT_DEF,
  parameter int unsigned RING_SLOTS       = kmdeq_pkg::RING_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kmdeq_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kmdeq_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import kmdeq_pkg::*;

  localparam int unsigned KEY_COUNT = MAX_ROW_COUNT * MAX_COLUMN_COUNT;
  localparam int unsigned KW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_DRAIN   = 4'b0100,
    ST_POP_OUT = 4'b1000
  } state_e;

  typedef struct packed {
    logic        down;
    logic [31:0] stamp;
  } key_entry_t;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] debounce_q;
  logic [4:0]  rows_cfg_q, cols_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      rows_cfg_q <= '0;
      cols_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_TIME:  debounce_q <= cfg_data_i;
        CFG_ROWS_IN_USE:    rows_cfg_q <= cfg_data_i[4:0];
        CFG_COLUMNS_IN_USE: cols_cfg_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // effective counts
  logic [4:0] nrows, ncols;
  assign nrows = (32'(rows_cfg_q) > MAX_ROW_COUNT) ? 5'(MAX_ROW_COUNT) : rows_cfg_q;
  assign ncols = (32'(cols_cfg_q) > MAX_COLUMN_COUNT) ? 5'(MAX_COLUMN_COUNT) : cols_cfg_q;

  // input handshake
  logic in_acc, acc_scan, acc_pop;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign acc_pop    = in_acc && (in_data_i.operation == OP_POP);
  assign acc_scan   = in_acc && (in_data_i.operation == OP_ROW_SAMPLE) &&
                      ({1'b0, in_data_i.row_index} < nrows) && (ncols != 5'd0);

  // latched sample
  logic [3:0]  row_q;
  logic [15:0] levels_q;
  logic [31:0] now_q;
  logic [4:0]  ncols_q;

  always_ff @(posedge clk_i) begin
    if (acc_scan) begin
      row_q    <= in_data_i.row_index;
      levels_q <= in_data_i.column_levels;
      now_q    <= in_data_i.now_ms;
      ncols_q  <= ncols;
    end
  end

  // column counter and read issue
  logic [3:0]    col_q;
  logic          last_col;
  logic          rd_en;
  logic [KW-1:0] rd_addr;

  assign rd_en    = (state_q == ST_SCAN);
  assign last_col = ((5'(col_q) + 5'd1) == ncols_q);
  assign rd_addr  = KW'(32'(row_q) * MAX_COLUMN_COUNT + 32'(col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (acc_scan) begin
      col_q <= '0;
    end else if (rd_en) begin
      col_q <= col_q + 4'd1;
    end
  end

  // key state memory with per-key valid bits
  key_entry_t    key_mem [KEY_COUNT];
  logic          key_vld_q [KEY_COUNT];
  key_entry_t    rd_q;
  logic          rd_vld_q;
  logic          ev_vld_q;
  logic [3:0]    ev_col_q;
  logic [KW-1:0] ev_addr_q;
  logic          wr_en;
  key_entry_t    wr_entry;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q     <= key_mem[rd_addr];
      rd_vld_q <= key_vld_q[rd_addr];
    end
    if (wr_en) begin
      key_mem[ev_addr_q] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        key_vld_q[i] <= 1'b0;
      end
    end else if (wr_en) begin
      key_vld_q[ev_addr_q] <= 1'b1;
    end
  end

  // evaluate stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q <= 1'b0;
    end else begin
      ev_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ev_col_q  <= col_q;
      ev_addr_q <= rd_addr;
    end
  end

  // debounce check and write back
  logic        cur_down, new_pressed;
  logic [31:0] cur_stamp, elapsed;
  assign cur_down    = rd_vld_q ? rd_q.down : 1'b0;
  assign cur_stamp   = rd_vld_q ? rd_q.stamp : 32'd0;
  assign new_pressed = ~levels_q[ev_col_q];
  assign elapsed     = now_q - cur_stamp;
  assign wr_en       = ev_vld_q && (new_pressed != cur_down) &&
                       (elapsed >= {16'd0, debounce_q});
  assign wr_entry    = '{down: new_pressed, stamp: now_q};

  // event ring
  ring_ctrl_t  ring_ctrl;
  ring_stat_t  ring_stat;
  ring_entry_t push_event, pop_event;

  assign ring_ctrl.push = wr_en;
  assign ring_ctrl.pop  = acc_pop;
  assign push_event     = '{row: row_q, column: ev_col_q, pressed: new_pressed};

  kmdeq_ring #(
    .RING_SLOTS(RING_SLOTS)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ring_ctrl),
    .push_event_i (push_event),
    .stat_o       (ring_stat),
    .pop_event_o  (pop_event)
  );

  logic pop_hit_q;
  always_ff @(posedge clk_i) begin
    if (acc_pop) begin
      pop_hit_q <= !ring_stat.empty;
    end
  end

  // sequencer
  logic out_load;
  assign out_load = (state_q == ST_POP_OUT) && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_scan) begin
          state_d = ST_SCAN;
        end else if (acc_pop) begin
          state_d = ST_POP_OUT;
        end
      end
      ST_SCAN: begin
        if (last_col) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:   state_d = ST_IDLE;
      ST_POP_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.event_valid   <= pop_hit_q;
      out_data_q.event_row     <= pop_hit_q ? pop_event.row : 4'd0;
      out_data_q.event_column  <= pop_hit_q ? pop_event.column : 4'd0;
      out_data_q.event_pressed <= pop_hit_q ? pop_event.pressed : 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> $past(state_q) == ST_SCAN) else $error("evaluate without a read");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("waiting result overwritten");
  a_pop_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == ST_IDLE) else $error("pop result not loaded");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == ST_SCAN || state_q == ST_DRAIN) else $error("key write outside scan");
`endif

endmodule

@@ tb/key_event_checker.sv @@
`timescale 1ns / 100ps
// checker for the key matrix scanner: mirrors key state and event ring, compares popped events
module key_event_checker
  import kmdeq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          fails_o
);

  localparam int ROW_LIMIT  = MAX_ROW_COUNT_DEF;
  localparam int COL_LIMIT  = MAX_COLUMN_COUNT_DEF;
  localparam int SLOTS      = RING_SLOTS_DEF;
  localparam int KEYS       = ROW_LIMIT * COL_LIMIT;
  localparam int PTR_W      = $clog2(SLOTS);

  // mirrored configuration
  logic [15:0] debounce_cfg;
  logic [4:0]  rows_cfg;
  logic [4:0]  cols_cfg;

  // mirrored key state and event ring
  logic [KEYS-1:0] key_is_down;
  logic [31:0]     change_stamp [KEYS];
  ring_entry_t     event_ring [SLOTS];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  // popped events still owed by the block, oldest first
  out_item_t due_events [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fails_o++;
  endtask

  // push one event unless the ring is full
  task automatic queue_event(input logic [3:0] row, input logic [3:0] col,
                             input logic pressed);
    logic [PTR_W-1:0] next_wr;
    next_wr = wr_ptr + 1'b1;
    if (next_wr != rd_ptr) begin
      event_ring[wr_ptr] = '{row: row, column: col, pressed: pressed};
      wr_ptr = next_wr;
    end
  endtask

  // debounce every examined key of one sampled row
  task automatic scan_row(input in_item_t item);
    int          nrows;
    int          ncols;
    int          key;
    logic        pressed;
    logic [31:0] elapsed;
    nrows = (rows_cfg > ROW_LIMIT) ? ROW_LIMIT : int'(rows_cfg);
    ncols = (cols_cfg > COL_LIMIT) ? COL_LIMIT : int'(cols_cfg);
    if (int'(item.row_index) < nrows) begin
      for (int c = 0; c < ncols; c++) begin
        key     = int'(item.row_index) * COL_LIMIT + c;
        pressed = ~item.column_levels[c];
        elapsed = item.now_ms - change_stamp[key];
        if (pressed != key_is_down[key] && elapsed >= {16'h0000, debounce_cfg}) begin
          key_is_down[key]  = pressed;
          change_stamp[key] = item.now_ms;
          queue_event(item.row_index, 4'(c), pressed);
        end
      end
    end
  endtask

  // a pop owes one result, valid or empty
  task automatic take_event();
    ring_entry_t ev;
    if (wr_ptr == rd_ptr) begin
      due_events.push_back('{event_valid: 1'b0, event_row: 4'h0, event_column: 4'h0,
                             event_pressed: 1'b0});
    end else begin
      ev = event_ring[rd_ptr];
      rd_ptr = rd_ptr + 1'b1;
      due_events.push_back('{event_valid: 1'b1, event_row: ev.row, event_column: ev.column,
                             event_pressed: ev.pressed});
    end
  endtask

  // compare one accepted result with the oldest owed one
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_events.size() == 0) begin
      report_mismatch("result item with no pop waiting");
      return;
    end
    want = due_events.pop_front();
    if (got.event_valid !== want.event_valid)
      report_mismatch($sformatf("event_valid got %b want %b", got.event_valid,
                                want.event_valid));
    if (got.event_row !== want.event_row)
      report_mismatch($sformatf("event_row got %0d want %0d", got.event_row,
                                want.event_row));
    if (got.event_column !== want.event_column)
      report_mismatch($sformatf("event_column got %0d want %0d", got.event_column,
                                want.event_column));
    if (got.event_pressed !== want.event_pressed)
      report_mismatch($sformatf("event_pressed got %b want %b", got.event_pressed,
                                want.event_pressed));
  endtask

  // watch config, result and input channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_cfg = DEBOUNCE_RESET;
      rows_cfg     = '0;
      cols_cfg     = '0;
      key_is_down  = '0;
      for (int k = 0; k < KEYS; k++) change_stamp[k] = '0;
      for (int s = 0; s < SLOTS; s++) event_ring[s] = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      due_events.delete();
      pending_o = 0;
      fails_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE_TIME:  debounce_cfg = cfg_data_i;
          CFG_ROWS_IN_USE:    rows_cfg     = cfg_data_i[4:0];
          CFG_COLUMNS_IN_USE: cols_cfg     = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.operation == OP_POP) take_event();
        else scan_row(in_data_i);
      end
      pending_o = due_events.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// top of the testbench: clock, reset, stimulus, watchdog and verdict for the key matrix scanner
module testbench;
  import kmdeq_pkg::*;

  localparam int         IDLE_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         RANDOM_PHASES = 12;
  localparam int         PHASE_ITEMS   = 78;
  localparam logic [1:0] CFG_SPARE     = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending_count;
  int          fail_count;

  // stimulus shaping state
  logic        calm;
  int          idle_cycles = 0;
  logic [31:0] clock_ms;
  logic [15:0] held_keys [16];
  logic [15:0] deb_now;
  int          rows_eff;
  int          cols_eff;

  key_matrix_debounce_event_queue_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  key_event_checker event_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending_count),
    .fails_o     (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one item on the input channel, optionally after a gap
  task automatic send_item(input in_item_t item);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pop();
    in_item_t item;
    item.operation     = OP_POP;
    item.row_index     = 4'($urandom);
    item.column_levels = 16'($urandom);
    item.now_ms        = $urandom;
    send_item(item);
  endtask

  task automatic send_sample(input logic [3:0] row, input logic [15:0] levels,
                             input logic [31:0] now);
    in_item_t item;
    item.operation     = OP_ROW_SAMPLE;
    item.row_index     = row;
    item.column_levels = levels;
    item.now_ms        = now;
    send_item(item);
  endtask

  // drop valid, wait for every owed result, then let any row scan finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_DEBOUNCE_TIME) deb_now = data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // matrix size registers, effective counts saturate at 16
  task automatic set_scan(input logic [15:0] rows_raw, input logic [15:0] cols_raw);
    write_reg(CFG_ROWS_IN_USE, rows_raw);
    write_reg(CFG_COLUMNS_IN_USE, cols_raw);
    rows_eff = (rows_raw[4:0] > 16) ? 16 : int'(rows_raw[4:0]);
    cols_eff = (cols_raw[4:0] > 16) ? 16 : int'(cols_raw[4:0]);
  endtask

  function automatic logic [15:0] size_word(input int count);
    return {11'($urandom), 5'(count)};
  endfunction

  // random output stall
  initial begin
    int free_len;
    int stall_len;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      free_len = calm ? 20 : $urandom_range(1, 12);
      repeat (free_len) @(negedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int          r;
    int          pop_pct;
    int          col;
    logic [3:0]  row;
    logic [15:0] levels;
    logic [15:0] col_mask;
    logic [15:0] deb_pick;
    calm      = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_DEBOUNCE_TIME;
    cfg_data  = '0;
    deb_now   = DEBOUNCE_RESET;
    rows_eff  = 0;
    cols_eff  = 0;
    clock_ms  = 32'd100;
    for (int i = 0; i < 16; i++) held_keys[i] = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, no rows in use
    send_pop();
    send_sample(4'd0, 16'h0000, 32'd0);

    // full matrix at reset debounce
    settle();
    set_scan(16'd16, 16'd16);
    end_writes();
    // too early after reset: rejected
    send_sample(4'd0, 16'h0000, 32'd3);
    // whole row pressed: ring fills, last event dropped
    send_sample(4'd0, 16'h0000, 32'd5);
    // ring full: events dropped, key state still moves
    send_sample(4'd15, 16'h7FFE, 32'hFFFF_FFFF);
    // drain all, then pop empty
    repeat (16) send_pop();

    // zero debounce, oversized row count, three columns, unused index
    settle();
    write_reg(CFG_DEBOUNCE_TIME, 16'd0);
    set_scan(16'hFFFF, 16'd3);
    write_reg(CFG_SPARE, 16'($urandom));
    end_writes();
    // time wraps past zero; upper column ignored
    send_sample(4'd15, 16'hFFFF, 32'd0);
    send_sample(4'd0, 16'hFFFF, 32'd0);
    send_pop();
    send_pop();

    // random phases over several settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CFG_DEBOUNCE_TIME, 16'hFFFF);
          set_scan(16'd16, 16'd16);
        end
        1: begin
          write_reg(CFG_DEBOUNCE_TIME, 16'd0);
          set_scan(size_word(1), size_word(1));
        end
        2: begin
          write_reg(CFG_DEBOUNCE_TIME, 16'd0);
          set_scan(size_word(31), size_word(31));
        end
        3: begin
          write_reg(CFG_DEBOUNCE_TIME, 16'd3);
          set_scan(16'd16, 16'd16);
        end
        4: begin
          write_reg(CFG_DEBOUNCE_TIME, 16'd1);
          set_scan(size_word(0), 16'd16);
        end
        default: begin
          r = $urandom_range(0, 99);
          if (r < 30) deb_pick = 16'($urandom_range(0, 10));
          else if (r < 80) deb_pick = 16'($urandom_range(0, 300));
          else deb_pick = 16'($urandom);
          write_reg(CFG_DEBOUNCE_TIME, deb_pick);
          set_scan(size_word(($urandom_range(0, 99) < 60) ? 16 : $urandom_range(0, 31)),
                   size_word(($urandom_range(0, 99) < 60) ? 16 : $urandom_range(0, 31)));
        end
      endcase
      end_writes();
      calm    = (p % 4 == 3);
      pop_pct = (p % 3 == 1) ? 10 : 35;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < pop_pct) begin
          send_pop();
        end else begin
          if (r < pop_pct + 8) begin
            // noise: any row, any levels
            row    = 4'($urandom_range(0, 15));
            levels = 16'($urandom);
          end else begin
            // key presses and releases that persist across samples
            row = (rows_eff > 0) ? 4'($urandom_range(0, rows_eff - 1))
                                 : 4'($urandom_range(0, 15));
            if (cols_eff > 0 && $urandom_range(0, 2) != 0) begin
              col = $urandom_range(0, cols_eff - 1);
              held_keys[row][col] = ~held_keys[row][col];
            end
            col_mask = (cols_eff >= 16) ? 16'hFFFF : 16'((32'd1 << cols_eff) - 1);
            levels   = (~held_keys[row] & col_mask) | (16'($urandom) & ~col_mask);
          end
          // time moves on, sometimes within the lock time, now and then jumps
          if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
          else if ($urandom_range(0, 1) == 1)
            clock_ms = clock_ms + $urandom_range(0, deb_now / 2 + 1);
          else clock_ms = clock_ms + $urandom_range(0, 2 * deb_now + 3);
          send_sample(row, levels, clock_ms);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
